>>> src/cfr_pkg.sv
`timescale 1ns / 1ps
package cfr_pkg;

  localparam int FRAMES     = 64;
  localparam int SLOT_BITS  = $clog2(FRAMES);
  localparam int PAGE_BITS  = 20;
  localparam int OWNER_BITS = 8;

  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(FRAMES - 1);

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_ACCESS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [PAGE_BITS-1:0]  frame_page;
    logic [PAGE_BITS-1:0]  user_page;
    logic [OWNER_BITS-1:0] owner;
    logic                  is_write;
  } cmd_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  frame;
    logic [PAGE_BITS-1:0]  user;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

endpackage

>>> src/cfr_if.sv
`timescale 1ns / 1ps
interface cfr_req_if;
  import cfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [PAGE_BITS-1:0]  frame_page;
  logic [PAGE_BITS-1:0]  user_page;
  logic [OWNER_BITS-1:0] owner;
  logic                  is_write;

  modport source (output valid, kind, frame_page, user_page, owner, is_write, input ready);
  modport sink   (input valid, kind, frame_page, user_page, owner, is_write, output ready);
endinterface

interface cfr_rsp_if;
  import cfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [SLOT_BITS-1:0]  slot;
  logic [PAGE_BITS-1:0]  victim_frame_page;
  logic [PAGE_BITS-1:0]  victim_user_page;
  logic [OWNER_BITS-1:0] victim_owner;
  logic                  victim_dirty;

  modport source (output valid, status, slot, victim_frame_page, victim_user_page,
                  victim_owner, victim_dirty, input ready);
  modport sink   (input valid, status, slot, victim_frame_page, victim_user_page,
                  victim_owner, victim_dirty, output ready);
endinterface

>>> src/cfr_front.sv
`timescale 1ns / 1ps
module cfr_front (
  input  logic          clk,
  input  logic          rst,
  cfr_req_if.sink       req,
  output logic          push,
  output cfr_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import cfr_pkg::*;

  logic hold_valid;
  logic hold_valid_next;
  cmd_t hold;
  cmd_t cls;
  logic req_fire;

  // Classify: keep the frame page, and only the other fields that the operation uses.
  always_comb begin
    cls            = '0;
    cls.kind       = kind_t'(req.kind);
    cls.frame_page = req.frame_page;
    if (kind_t'(req.kind) == KIND_ADD) begin
      cls.user_page = req.user_page;
      cls.owner     = req.owner;
    end
    if (kind_t'(req.kind) == KIND_ACCESS) begin
      cls.is_write = req.is_write;
    end
  end

  assign req.ready = !hold_valid || !q_full;
  assign req_fire  = req.valid && req.ready;
  assign push      = hold_valid && !q_full;
  assign push_cmd  = hold;

  always_comb begin
    hold_valid_next = hold_valid;
    if (req_fire) begin
      hold_valid_next = 1'b1;
    end else if (push) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
    if (req_fire) begin
      hold <= cls;
    end
  end

endmodule

>>> src/cfr_queue.sv
`timescale 1ns / 1ps
module cfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output cfr_pkg::cmd_t q_cmd
);
  import cfr_pkg::*;

  cmd_t                  entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  do_pop;

  assign full    = (count == Q_CNT_BITS'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> src/cfr_back.sv
`timescale 1ns / 1ps
module cfr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cfr_pkg::cmd_t q_cmd,
  output logic          pop,
  cfr_rsp_if.source     rsp
);
  import cfr_pkg::*;

  back_state_t           state, state_next;
  cmd_t                  cmd, cmd_next;
  logic [SLOT_BITS-1:0]  idx, idx_next;
  logic [SLOT_BITS-1:0]  hand, hand_next;
  logic                  hand_started, hand_started_next;
  logic [FRAMES-1:0]     valid_bits, valid_bits_next;
  logic [FRAMES-1:0]     acc_bits, acc_bits_next;
  logic [FRAMES-1:0]     dirty_bits, dirty_bits_next;

  entry_t                mem [FRAMES];
  entry_t                rd_data;
  logic                  mem_we;

  logic                  res_valid, res_valid_next;
  status_t               res_status, res_status_next;
  logic [SLOT_BITS-1:0]  res_slot, res_slot_next;
  entry_t                res_victim, res_victim_next;
  logic                  res_dirty, res_dirty_next;

  logic                  out_free;
  logic                  hit;
  logic [SLOT_BITS-1:0]  idx_inc;
  logic [SLOT_BITS-1:0]  hand_inc;

  assign out_free = !res_valid || rsp.ready;
  assign hit      = valid_bits[idx] && (rd_data.frame == cmd.frame_page);
  assign idx_inc  = (idx == SLOT_LAST) ? '0 : idx + 1'b1;
  assign hand_inc = (hand == SLOT_LAST) ? '0 : hand + 1'b1;

  assign rsp.valid             = res_valid;
  assign rsp.status            = res_status;
  assign rsp.slot              = res_slot;
  assign rsp.victim_frame_page = res_victim.frame;
  assign rsp.victim_user_page  = res_victim.user;
  assign rsp.victim_owner      = res_victim.owner;
  assign rsp.victim_dirty      = res_dirty;

  always_comb begin
    state_next        = state;
    cmd_next          = cmd;
    idx_next          = idx;
    hand_next         = hand;
    hand_started_next = hand_started;
    valid_bits_next   = valid_bits;
    acc_bits_next     = acc_bits;
    dirty_bits_next   = dirty_bits;
    mem_we            = 1'b0;
    pop               = 1'b0;
    res_valid_next    = res_valid && !rsp.ready;
    res_status_next   = res_status;
    res_slot_next     = res_slot;
    res_victim_next   = res_victim;
    res_dirty_next    = res_dirty;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          cmd_next   = q_cmd;
          state_next = BK_RUN;
          idx_next   = (q_cmd.kind == KIND_EVICT && hand_started) ? hand_inc : '0;
        end
      end
      BK_RUN: begin
        if (out_free) begin
          res_victim_next = '0;
          res_dirty_next  = 1'b0;
          res_slot_next   = '0;
          case (cmd.kind)
            KIND_ADD: begin
              if (!valid_bits[idx]) begin
                valid_bits_next[idx] = 1'b1;
                acc_bits_next[idx]   = 1'b0;
                dirty_bits_next[idx] = 1'b0;
                mem_we               = 1'b1;
                res_status_next      = ST_OK;
                res_slot_next        = idx;
                res_valid_next       = 1'b1;
                state_next           = BK_IDLE;
              end else if (idx == SLOT_LAST) begin
                res_status_next = ST_FULL;
                res_valid_next  = 1'b1;
                state_next      = BK_IDLE;
              end else begin
                idx_next = idx_inc;
              end
            end
            KIND_FREE, KIND_ACCESS: begin
              if (hit) begin
                if (cmd.kind == KIND_FREE) begin
                  valid_bits_next[idx] = 1'b0;
                  acc_bits_next[idx]   = 1'b0;
                  dirty_bits_next[idx] = 1'b0;
                end else begin
                  acc_bits_next[idx]   = 1'b1;
                  dirty_bits_next[idx] = dirty_bits[idx] | cmd.is_write;
                end
                res_status_next = ST_OK;
                res_slot_next   = idx;
                res_valid_next  = 1'b1;
                state_next      = BK_IDLE;
              end else if (idx == SLOT_LAST) begin
                res_status_next = ST_NOT_FOUND;
                res_valid_next  = 1'b1;
                state_next      = BK_IDLE;
              end else begin
                idx_next = idx_inc;
              end
            end
            KIND_EVICT: begin
              if (valid_bits == '0) begin
                res_status_next = ST_EMPTY;
                res_valid_next  = 1'b1;
                state_next      = BK_IDLE;
              end else if (valid_bits[idx] && !acc_bits[idx]) begin
                valid_bits_next[idx] = 1'b0;
                acc_bits_next[idx]   = 1'b0;
                dirty_bits_next[idx] = 1'b0;
                hand_next            = idx;
                hand_started_next    = 1'b1;
                res_status_next      = ST_OK;
                res_slot_next        = idx;
                res_victim_next      = rd_data;
                res_dirty_next       = dirty_bits[idx];
                res_valid_next       = 1'b1;
                state_next           = BK_IDLE;
              end else begin
                // Second chance: drop the accessed bit and move on.
                if (valid_bits[idx]) begin
                  acc_bits_next[idx] = 1'b0;
                end
                idx_next = idx_inc;
              end
            end
            default: begin
              state_next = BK_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hand_started <= 1'b0;
      hand         <= '0;
      valid_bits   <= '0;
      acc_bits     <= '0;
      dirty_bits   <= '0;
      res_valid    <= 1'b0;
    end else begin
      hand_started <= hand_started_next;
      hand         <= hand_next;
      valid_bits   <= valid_bits_next;
      acc_bits     <= acc_bits_next;
      dirty_bits   <= dirty_bits_next;
      res_valid    <= res_valid_next;
    end
    cmd        <= cmd_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_victim <= res_victim_next;
    res_dirty  <= res_dirty_next;
  end

  // Read at the next scan index so that the entry under idx is ready in the cycle it is used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= '{frame: cmd.frame_page, user: cmd.user_page, owner: cmd.owner};
    end
    rd_data <= mem[idx_next];
  end

endmodule

>>> src/clock_frame_replacement_unit.sv
`timescale 1ns / 1ps
// Path: a request transfer goes into the front holding register, then the queue, then the
// back's command register; the scan walks slots from its start and stops at the first that
// ends it, and an evict passes the table at most twice. The single scan sequencer takes a new
// command only once the last scan is done, and an untaken result stalls the scan.
// Reset: synchronous, clears valid, accessed and dirty bits, hand and queues at once;
// the frame/user/owner memory is not cleared and no clearing pass runs.
module clock_frame_replacement_unit (
  input  logic      clk,
  input  logic      rst,
  cfr_req_if.sink   req,
  cfr_rsp_if.source rsp
);
  import cfr_pkg::*;

  // Front to queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // Queue to back
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // Front: take each request transfer into a holding register, tidy unused fields,
  // and hand it to the queue as soon as there is room.
  cfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Short command queue: lets the front keep taking requests while the back scans.
  cfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back: owns the frame table and the clock hand. Each command walks the table one
  // slot a cycle while the output register is free:
  //   add    - stop at the lowest invalid slot and write it, else report full
  //   free   - stop at the lowest valid slot whose frame page matches and release it
  //   access - same search, set accessed and, on a write, dirty
  //   evict  - start one past the last victim (slot 0 the first time), clear accessed
  //            bits it meets, stop at the first valid unaccessed slot, else report empty
  // The result goes into an output register, so the next command can start while it
  // waits for transfer.
  cfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule
